// ===== rtl/kct_pkg.sv =====
`default_nettype none

package kct_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned IN_W    = MODE_W + 2 * ID_W + CNT_W;
  localparam int unsigned IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W   = STAT_W + 1 + CNT_W;
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_GET = 2'd1,
    MODE_DEL = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0] amount;
    logic [ID_W-1:0]  field_id;
    logic [ID_W-1:0]  key_id;
    logic [MODE_W-1:0] mode;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count_value;
    logic              found;
    logic [STAT_W-1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/keyed_counter_table_core.sv =====
// A request passes stage A (match), stage B (update) and then the output register.
// Throughput: one request per cycle unless the result side stalls; all slots are matched in parallel and the
// counter memory has one read and one write port, with write-to-read forwarding.
// Backpressure on the result side stalls the stages in order.
// Reset (rst_ni low, asynchronous) clears all valid marks and the pipeline;
// key, field and counter storage are not reset.
`default_nettype none

module keyed_counter_table_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // mode[1:0], key_id[33:2], field_id[65:34], amount[97:66], zero pad
  input  wire  [kct_pkg::IN_TW-1:0]        s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // status[1:0], found[2], count_value[34:3], zero pad
  output logic [kct_pkg::OUT_TW-1:0]       m_axis_tdata_o
);
  import kct_pkg::*;

  // stage A: request register
  logic             a_vq;
  req_t             a_q;

  // stage B: counter update
  logic             b_vq;
  logic             b_wr_q;
  logic             b_create_q;
  logic             b_rdout_q;
  logic [IDX_W-1:0] b_slot_q;
  logic [CNT_W-1:0] b_amount_q;
  logic             b_found_q;
  status_e          b_status_q;
  logic [CNT_W-1:0] mem_rd_q;
  logic             fwd_q;
  logic [CNT_W-1:0] fwd_data_q;

  // output register
  logic             o_vq;
  rsp_t             o_q;

  // table
  logic [ENTRIES-1:0] valid_q;
  logic [ID_W-1:0]    key_q   [ENTRIES];
  logic [ID_W-1:0]    field_q [ENTRIES];
  logic [CNT_W-1:0]   count_mem [ENTRIES];

  logic o_ready, b_ready, a_ready;
  logic a_fire, b_fire, s_fire;

  assign o_ready = !o_vq || m_axis_tready_i;
  assign b_ready = !b_vq || o_ready;
  assign a_ready = !a_vq || b_ready;
  assign b_fire  = b_vq && o_ready;
  assign a_fire  = a_vq && b_ready;
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = a_ready;

  // parallel match and free-slot search
  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic               hit_any;
  logic               free_any;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == a_q.key_id) && (field_q[i] == a_q.field_id);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_idx = hit_idx | (match[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |match;
  assign free_any = ~&valid_q;

  // stage A decision
  logic       a_create, a_del, a_wr, a_rdout, a_found;
  status_e    a_status;
  logic [IDX_W-1:0] a_slot;

  always_comb begin
    a_create = 1'b0;
    a_del    = 1'b0;
    a_wr     = 1'b0;
    a_rdout  = 1'b0;
    a_found  = 1'b0;
    a_status = ST_OK;
    a_slot   = hit_idx;
    unique case (a_q.mode)
      MODE_ADD: begin
        if (hit_any) begin
          a_wr    = 1'b1;
          a_found = 1'b1;
        end else if (free_any) begin
          a_wr     = 1'b1;
          a_create = 1'b1;
          a_slot   = free_idx;
        end else begin
          a_status = ST_FULL;
        end
      end
      MODE_GET: begin
        if (hit_any) begin
          a_rdout = 1'b1;
          a_found = 1'b1;
        end else begin
          a_status = ST_MISSING;
        end
      end
      MODE_DEL: begin
        if (hit_any) begin
          a_del   = 1'b1;
          a_found = 1'b1;
        end else begin
          a_status = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  // stage B arithmetic
  logic [CNT_W-1:0] b_rd;
  logic [CNT_W-1:0] b_new;
  logic [CNT_W-1:0] b_value;

  assign b_rd    = fwd_q ? fwd_data_q : mem_rd_q;
  assign b_new   = b_create_q ? b_amount_q : b_rd + b_amount_q;
  assign b_value = b_wr_q ? b_new : (b_rdout_q ? b_rd : '0);

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vq <= 1'b0;
      b_vq <= 1'b0;
      o_vq <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vq <= s_axis_tvalid_i;
      end
      if (b_ready) begin
        b_vq <= a_vq;
      end
      if (o_ready) begin
        o_vq <= b_vq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_q <= req_t'(s_axis_tdata_i[IN_W-1:0]);
    end
    if (a_fire) begin
      b_wr_q     <= a_wr;
      b_create_q <= a_create;
      b_rdout_q  <= a_rdout;
      b_slot_q   <= a_slot;
      b_amount_q <= a_q.amount;
      b_found_q  <= a_found;
      b_status_q <= a_status;
      fwd_q      <= b_vq && b_wr_q && (b_slot_q == a_slot);
      fwd_data_q <= b_new;
    end
    if (b_fire) begin
      o_q.status      <= b_status_q;
      o_q.found       <= b_found_q;
      o_q.count_value <= b_value;
    end
  end

  // counter memory
  always_ff @(posedge clk_i) begin
    if (b_fire && b_wr_q) begin
      count_mem[b_slot_q] <= b_new;
    end
    if (a_fire) begin
      mem_rd_q <= count_mem[a_slot];
    end
  end

  // tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (a_fire) begin
      if (a_create) begin
        valid_q[free_idx] <= 1'b1;
      end else if (a_del) begin
        valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && a_create) begin
      key_q[free_idx]   <= a_q.key_id;
      field_q[free_idx] <= a_q.field_id;
    end
  end

  assign m_axis_tvalid_o = o_vq;
  assign m_axis_tdata_o  = {{(OUT_TW - OUT_W){1'b0}}, o_q};

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one slot holds the same pair");

  a_create_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && a_create) |=> valid_q[$past(free_idx)])
    else $error("created slot not marked valid");

  a_delete_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && a_del) |=> !valid_q[$past(hit_idx)])
    else $error("deleted slot still marked valid");

endmodule

`default_nettype wire

// ===== test/keyed_counter_table_core_test.sv =====
`default_nettype none

module keyed_counter_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kct_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 780;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT = 38;

  class counter_table_scoreboard;
    bit              slot_valid [ENTRIES];
    bit [ID_W-1:0]   slot_key   [ENTRIES];
    bit [ID_W-1:0]   slot_field [ENTRIES];
    bit [CNT_W-1:0]  slot_count [ENTRIES];
    rsp_t            pending_rsp[$];
    int unsigned     mismatches;

    function int match_slot(logic [ID_W-1:0] key, logic [ID_W-1:0] field);
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_key[i] == key && slot_field[i] == field) return i;
      end
      return -1;
    endfunction

    function int lowest_free_slot();
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_valid[i]) return i;
      end
      return -1;
    endfunction

    function void note_request(req_t r);
      int   hit;
      int   free_idx;
      rsp_t want;
      hit = match_slot(r.key_id, r.field_id);
      want = '0;
      want.status = ST_OK;
      case (r.mode)
        MODE_ADD: begin
          if (hit >= 0) begin
            slot_count[hit] = slot_count[hit] + r.amount;
            want.found = 1'b1;
            want.count_value = slot_count[hit];
          end else begin
            free_idx = lowest_free_slot();
            if (free_idx >= 0) begin
              slot_valid[free_idx] = 1'b1;
              slot_key[free_idx]   = r.key_id;
              slot_field[free_idx] = r.field_id;
              slot_count[free_idx] = r.amount;
              want.count_value = r.amount;
            end else begin
              want.status = ST_FULL;
            end
          end
        end
        MODE_GET: begin
          if (hit >= 0) begin
            want.found = 1'b1;
            want.count_value = slot_count[hit];
          end else begin
            want.status = ST_MISSING;
          end
        end
        MODE_DEL: begin
          if (hit >= 0) begin
            slot_valid[hit] = 1'b0;
            want.found = 1'b1;
          end else begin
            want.status = ST_MISSING;
          end
        end
        default: ;  // unused mode: no change, all-zero result
      endcase
      pending_rsp = {pending_rsp, want};
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status=%0d found=%0d count=%08h",
                 $time, got.status, got.found, got.count_value);
        mismatches++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found mismatch: expected %0d, got %0d", $time, want.found, got.found);
        mismatches++;
      end
      if (got.count_value !== want.count_value) begin
        $display("%0t: count_value mismatch: expected %08h, got %08h",
                 $time, want.count_value, got.count_value);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic [IN_TW-1:0]    s_axis_tdata_i = '0;
  logic                m_axis_tready_i = 1'b0;
  wire                 s_axis_tready_o;
  wire                 m_axis_tvalid_o;
  wire  [OUT_TW-1:0]   m_axis_tdata_o;

  bit                  steady = 1'b0;
  int unsigned         cycle_count = 0;
  counter_table_scoreboard sb = new();

  keyed_counter_table_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o === 1'b1 && m_axis_tready_i)
        sb.check_result(rsp_t'(m_axis_tdata_o[OUT_W-1:0]));
      m_axis_tready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] key,
                               input logic [ID_W-1:0] field, input logic [CNT_W-1:0] amount);
    req_t r;
    r.mode     = mode;
    r.key_id   = key;
    r.field_id = field;
    r.amount   = amount;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TW-IN_W){1'b0}}, r};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    sb.note_request(r);
  endtask

  // lowers valid and holds off until the table has answered every request
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_rsp.size() != 0);
  endtask

  function automatic logic [CNT_W-1:0] pick_amount();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(int add_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4) return MODE_UNUSED;
    if (r < add_pct) return MODE_ADD;
    if (r < add_pct + (100 - add_pct) / 2) return MODE_GET;
    return MODE_DEL;
  endfunction

  initial begin
    int unsigned   sent;
    int unsigned   round_idx;
    int            add_pct;
    int            nk;
    int            nf;
    logic [ID_W-1:0] pool_key [9];
    logic [ID_W-1:0] pool_field [9];
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] field;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misses on an empty table, zero add, wrap, extremes, unused mode, slot reuse
    issue_request(MODE_GET, '0, '0, '0);
    issue_request(MODE_DEL, '0, '0, '0);
    issue_request(MODE_ADD, '0, '0, '0);
    issue_request(MODE_ADD, '1, '1, 32'h7fff_ffff);
    issue_request(MODE_ADD, '1, '1, 32'd1);
    issue_request(MODE_ADD, '1, '1, 32'h8000_0000);
    issue_request(MODE_GET, '1, '1, '1);
    issue_request(MODE_ADD, '0, '1, '1);
    issue_request(MODE_ADD, '1, '0, 32'h8000_0000);
    issue_request(MODE_ADD, '1, '0, 32'h8000_0000);
    issue_request(MODE_UNUSED, '1, '1, '1);
    issue_request(MODE_UNUSED, '0, '0, '0);
    issue_request(MODE_GET, '0, '0, '1);
    issue_request(MODE_DEL, '0, '0, '1);
    issue_request(MODE_GET, '0, '0, '0);
    issue_request(MODE_DEL, '0, '0, '0);
    issue_request(MODE_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'd5);
    issue_request(MODE_GET, 32'h5555_5555, 32'haaaa_aaaa, '0);
    issue_request(MODE_GET, 32'haaaa_aaaa, 32'h5555_5555, '0);
    issue_request(MODE_DEL, '1, '1, '0);
    issue_request(MODE_DEL, '0, '1, '0);
    issue_request(MODE_DEL, '1, '0, '0);
    issue_request(MODE_DEL, 32'h5555_5555, 32'haaaa_aaaa, '0);
    wait_for_results();

    sent = 0;
    round_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (round_idx == 4 || round_idx == 5);
      foreach (pool_key[j]) begin
        pool_key[j]   = $urandom();
        pool_field[j] = $urandom();
      end
      if (round_idx % 5 == 2) begin
        // fill past capacity, then issue random deletes and lookups on the same pairs
        for (int j = 0; j < 72; j++)
          issue_request(MODE_ADD, pool_key[j / 8], pool_field[j % 8], pick_amount());
        for (int j = 0; j < 72; j++) begin
          key   = pool_key[$urandom_range(8)];
          field = pool_field[$urandom_range(7)];
          issue_request(($urandom_range(9) < 7) ? MODE_DEL : MODE_GET, key, field, $urandom());
        end
        sent += 144;
      end else begin
        nk = $urandom_range(1, 9);
        nf = $urandom_range(1, 9);
        add_pct = $urandom_range(20, 80);
        repeat (50) begin
          if ($urandom_range(9) == 0) begin
            key   = $urandom();
            field = $urandom();
          end else begin
            key   = pool_key[$urandom_range(nk - 1)];
            field = pool_field[$urandom_range(nf - 1)];
          end
          issue_request(pick_mode(add_pct), key, field, pick_amount());
        end
        sent += 50;
      end
      if (round_idx == 3 || $urandom_range(2) == 0) wait_for_results();
      round_idx++;
    end
    steady = 1'b0;

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_rsp.size() != 0);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/kct_pkg.sv
rtl/keyed_counter_table_core.sv
test/keyed_counter_table_core_test.sv
